>>> rtl/rfa_pkg.sv
// Package for the rational fraction ALU: payload structs, op and status codes,
// sequencer states. No dependencies.
package rfa_pkg;

  localparam int WORD_BITS_DEF = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } rfa_in_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic [1:0]         status;
  } rfa_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED_A,
    S_RED_B,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_COMBINE,
    S_RED_R,
    S_DONE
  } state_t;

  // Reduction sub-steps: gcd by repeated mod, then two divisions.
  typedef enum logic [2:0] {
    R_INIT,
    R_GCD,
    R_DIVN,
    R_DIVD,
    R_END
  } rphase_t;

endpackage

>>> rtl/rational_fraction_alu.sv
// Rational fraction ALU top level: sequencer around one shared shift-subtract
// divider and one shared multiplier. Depends on rfa_pkg.
//
// Channel  | Ports                        | Beat
// ---------+------------------------------+---------------------------------
// input    | start, busy, in_data         | start && !busy at rising edge
// result   | out_valid, out_data          | out_valid, one cycle, no stall
//
// Each remainder or quotient holds the shared bit-serial divider from launch
// through done; three reductions each run a data-dependent number of gcd
// steps plus two divisions, so the time per item depends on the operands and
// is longest when Euclid hits its worst case on the double-width result.
// Zero denominators skip the reductions and go straight to the done state.
// Reset is synchronous, active low, and clears sequencer and strobe.
// The receiver cannot stall: the result is shown for one cycle, and busy
// stays high until that cycle.
module rational_fraction_alu import rfa_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  rfa_in_t  in_data,
  output logic     out_valid,
  output rfa_out_t out_data
);

  localparam int DW  = 2 * WORD_BITS;      // double width for products
  localparam int CW  = $clog2(DW + 1);

  state_t  state_r, state_nxt;
  rphase_t rph_r;

  logic [1:0]    op_r;
  logic          an_neg_r, ad_neg_r, bn_neg_r, bd_neg_r, rn_neg_r;
  logic [DW-1:0] an_r, ad_r, bn_r, bd_r, rn_r, rd_r;
  logic [DW-1:0] t1_r;

  // reduction working regs
  logic [DW-1:0] gx_r, gy_r;

  // shared divider: quotient/remainder of dividend by divisor, bit serial
  logic [DW-1:0] dv_n_r, dv_d_r, dv_q_r, dv_rem_r;
  logic [CW-1:0] dv_cnt_r;
  logic          dv_run_r;
  logic          dv_go;
  logic [DW-1:0] dv_go_n, dv_go_d;
  logic [DW:0]   dv_trial;
  logic          dv_done;

  logic [DW-1:0] mul_a, mul_b, mul_p;

  rfa_out_t res_r;
  logic     vld_r;

  function automatic logic [DW-1:0] mag_of(input logic [31:0] raw);
    logic [WORD_BITS-1:0] v;
    v = raw[WORD_BITS-1:0];
    if (v[WORD_BITS-1]) v = ~v + 1'b1;
    return DW'(v);
  endfunction

  // --- shared divider ---
  assign dv_trial = {dv_rem_r, dv_n_r[DW-1]} - {1'b0, dv_d_r};
  assign dv_done  = dv_run_r && (dv_cnt_r == CW'(0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_run_r <= 1'b0;
    end else if (dv_go) begin
      dv_run_r <= 1'b1;
      dv_cnt_r <= CW'(DW);
      dv_n_r   <= dv_go_n;
      dv_d_r   <= dv_go_d;
      dv_q_r   <= '0;
      dv_rem_r <= '0;
    end else if (dv_run_r) begin
      if (dv_cnt_r == CW'(0)) begin
        dv_run_r <= 1'b0;
      end else begin
        // advance one quotient bit
        dv_cnt_r <= dv_cnt_r - 1'b1;
        dv_n_r   <= {dv_n_r[DW-2:0], 1'b0};
        if (!dv_trial[DW]) begin
          dv_rem_r <= dv_trial[DW-1:0];
          dv_q_r   <= {dv_q_r[DW-2:0], 1'b1};
        end else begin
          dv_rem_r <= {dv_rem_r[DW-2:0], dv_n_r[DW-1]};
          dv_q_r   <= {dv_q_r[DW-2:0], 1'b0};
        end
      end
    end
  end

  // --- shared multiplier, WORD_BITS x WORD_BITS ---
  assign mul_p = mul_a[WORD_BITS-1:0] * mul_b[WORD_BITS-1:0];

  always_comb begin
    mul_a = an_r;
    mul_b = bd_r;
    case (state_r)
      S_MUL1: begin
        mul_a = an_r;
        mul_b = (op_r == OP_MUL) ? bn_r : bd_r;
      end
      S_MUL2: begin
        mul_a = (op_r == OP_DIV) ? ad_r : bn_r;
        mul_b = (op_r == OP_DIV) ? bn_r : ad_r;
      end
      S_MUL3: begin
        mul_a = ad_r;
        mul_b = bd_r;
      end
      default: ;
    endcase
  end

  // selected pair for the reduction in progress
  logic [DW-1:0] sel_n, sel_d;
  always_comb begin
    case (state_r)
      S_RED_A: begin sel_n = an_r; sel_d = ad_r; end
      S_RED_B: begin sel_n = bn_r; sel_d = bd_r; end
      default: begin sel_n = rn_r; sel_d = rd_r; end
    endcase
  end

  logic red_state;
  assign red_state = (state_r == S_RED_A) || (state_r == S_RED_B) ||
                     (state_r == S_RED_R);

  // divider launch
  always_comb begin
    dv_go   = 1'b0;
    dv_go_n = gx_r;
    dv_go_d = gy_r;
    if (red_state && !dv_run_r) begin
      case (rph_r)
        R_GCD: begin
          dv_go = (gy_r != '0);
        end
        R_DIVN: begin
          dv_go = 1'b1; dv_go_n = sel_n; dv_go_d = gx_r;
        end
        R_DIVD: begin
          dv_go = 1'b1; dv_go_n = sel_d; dv_go_d = gx_r;
        end
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (mag_of(in_data.a_den) == '0 || mag_of(in_data.b_den) == '0)
            state_nxt = S_DONE;
          else
            state_nxt = S_RED_A;
        end
      end
      S_RED_A: if (rph_r == R_END) state_nxt = S_RED_B;
      S_RED_B: begin
        if (rph_r == R_END)
          state_nxt = (op_r == OP_DIV && bn_r == '0) ? S_DONE : S_MUL1;
      end
      S_MUL1:    state_nxt = S_MUL2;
      S_MUL2:    state_nxt = S_MUL3;
      S_MUL3:    state_nxt = S_COMBINE;
      S_COMBINE: state_nxt = S_RED_R;
      S_RED_R:   if (rph_r == R_END) state_nxt = S_DONE;
      S_DONE:    state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy      = (state_r != S_IDLE);
    out_valid = vld_r;
    out_data  = res_r;
  end

  localparam logic [DW-1:0] HALF = DW'(1) << (WORD_BITS - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rph_r   <= R_INIT;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // strobe the result, registered from the done state
      vld_r   <= (state_r == S_DONE);
      if (state_r != state_nxt) rph_r <= R_INIT;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r     <= in_data.req_type;
            an_r     <= mag_of(in_data.a_num);
            ad_r     <= mag_of(in_data.a_den);
            bn_r     <= mag_of(in_data.b_num);
            bd_r     <= mag_of(in_data.b_den);
            an_neg_r <= in_data.a_num[WORD_BITS-1];
            ad_neg_r <= in_data.a_den[WORD_BITS-1];
            bn_neg_r <= in_data.b_num[WORD_BITS-1];
            bd_neg_r <= in_data.b_den[WORD_BITS-1];
            res_r    <= '{res_num: '0, res_den: '0, status: ST_ZERO_DEN};
          end
        end
        S_MUL1: t1_r <= mul_p;
        S_MUL2: begin
          if (op_r == OP_ADD || op_r == OP_SUB) begin
            // hold t2 in rd_r until S_MUL3 parks it in rn_r
            rd_r <= mul_p;
          end else begin
            rn_r     <= t1_r;
            rd_r     <= mul_p;
            rn_neg_r <= an_neg_r ^ bn_neg_r;
          end
        end
        S_MUL3: begin
          if (op_r == OP_ADD || op_r == OP_SUB) begin
            rn_r <= rd_r;   // t2 parked
            rd_r <= mul_p;
          end else begin
            rn_r <= t1_r;
            // product of the denominators for multiply
            if (op_r == OP_MUL) rd_r <= mul_p;
          end
        end
        S_COMBINE: begin
          if (op_r == OP_ADD || op_r == OP_SUB) begin
            // t1 sign an_neg_r, t2 sign bn_neg_r flipped for subtract
            if (an_neg_r == (bn_neg_r ^ (op_r == OP_SUB))) begin
              rn_r     <= t1_r + rn_r;
              rn_neg_r <= an_neg_r;
            end else if (t1_r >= rn_r) begin
              rn_r     <= t1_r - rn_r;
              rn_neg_r <= an_neg_r;
            end else begin
              rn_r     <= rn_r - t1_r;
              rn_neg_r <= ~an_neg_r;
            end
          end
        end
        S_RED_A, S_RED_B, S_RED_R: begin
          case (rph_r)
            R_INIT: begin
              gx_r  <= sel_n;
              gy_r  <= sel_d;
              rph_r <= R_GCD;
            end
            R_GCD: begin
              if (!dv_run_r && gy_r == '0) begin
                if (gx_r == '0) gx_r <= DW'(1);
                rph_r <= R_DIVN;
              end else if (dv_done) begin
                gx_r <= gy_r;
                gy_r <= dv_rem_r;
              end
            end
            R_DIVN: begin
              if (dv_done) begin
                gy_r  <= dv_q_r;   // reduced numerator parked
                rph_r <= R_DIVD;
              end
            end
            R_DIVD: begin
              if (dv_done) begin
                rph_r <= R_END;
                case (state_r)
                  S_RED_A: begin
                    an_r     <= gy_r;
                    ad_r     <= dv_q_r;
                    an_neg_r <= (gy_r != '0) && (an_neg_r != ad_neg_r);
                  end
                  S_RED_B: begin
                    bn_r     <= gy_r;
                    bd_r     <= dv_q_r;
                    bn_neg_r <= (gy_r != '0) && (bn_neg_r != bd_neg_r);
                  end
                  default: begin
                    rn_r     <= gy_r;
                    rd_r     <= (gy_r == '0) ? DW'(1) : dv_q_r;
                    rn_neg_r <= (gy_r != '0) && rn_neg_r;
                  end
                endcase
              end
            end
            default: ;
          endcase
        end
        S_DONE: begin
          if (ad_r == '0 || bd_r == '0) begin
            res_r <= '{res_num: '0, res_den: '0, status: ST_ZERO_DEN};
          end else if (op_r == OP_DIV && bn_r == '0) begin
            res_r <= '{res_num: '0, res_den: '0, status: ST_DIV_ZERO};
          end else if ((rn_neg_r ? (rn_r > HALF) : (rn_r > HALF - 1'b1)) ||
                       rd_r > HALF - 1'b1) begin
            res_r <= '{res_num: '0, res_den: '0, status: ST_OVERFLOW};
          end else begin
            res_r.res_num <= 32'(rn_neg_r ? (DW'(0) - rn_r) : rn_r);
            res_r.res_den <= 31'(rd_r);
            res_r.status  <= ST_OK;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted start without busy");
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result strobe");
  a_den_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_OK) |-> (out_data.res_den != '0))
    else $error("zero denominator on ok result");
`endif

endmodule

>>> verif/rational_fraction_alu_tb.sv
// Testbench for the rational fraction ALU: directed table plus random items,
// checked field by field against literals or predict_fraction. Depends on rfa_pkg.
`timescale 1ns / 1ps

module rational_fraction_alu_tb import rfa_pkg::*; ();

  localparam int WB = WORD_BITS_DEF;
  localparam longint unsigned CYCLE_LIMIT = 64'd20000000;
  localparam int N_RANDOM = 500;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  rfa_in_t  in_data;
  logic     out_valid;
  rfa_out_t out_data;

  rational_fraction_alu #(.WORD_BITS(WB)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Expected results, oldest first.
  rfa_out_t pending_q[$];
  int  n_fail;
  longint unsigned cycles;

  // Directed rows: operands plus an optional typed-in expectation.
  typedef struct {
    rfa_in_t  item;
    bit       has_lit;
    rfa_out_t lit;
  } row_t;
  row_t rows[$];

  function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y; x = y; y = t;
    end
    return x;
  endfunction

  // Split a field into sign and magnitude at the block's word width.
  function automatic void split_word(logic [31:0] raw, output bit neg,
                                     output longint unsigned mag);
    longint unsigned v;
    longint unsigned msk;
    msk = (64'd1 << WB) - 1;
    v = {32'd0, raw} & msk;
    neg = v[WB-1];
    mag = neg ? ((~v + 1) & msk) : v;
  endfunction

  function automatic void lowest_terms(inout bit nn, inout longint unsigned nm,
                                       inout bit dn, inout longint unsigned dm);
    longint unsigned g;
    g = gcd64(nm, dm);
    if (g == 0) g = 1;
    nm = nm / g;
    dm = dm / g;
    nn = (nm != 0) && (nn != dn);
    dn = 0;
  endfunction

  function automatic rfa_out_t predict_fraction(rfa_in_t it);
    rfa_out_t r;
    bit an_s, ad_s, bn_s, bd_s, rn_s, rd_s, t1_s, t2_s;
    longint unsigned an, ad, bn, bd, rn, rd, t1, t2, half;
    half = 64'd1 << (WB - 1);
    r = '0;
    split_word(it.a_num, an_s, an);
    split_word(it.a_den, ad_s, ad);
    split_word(it.b_num, bn_s, bn);
    split_word(it.b_den, bd_s, bd);
    if (ad == 0 || bd == 0) begin
      r.status = ST_ZERO_DEN;
      return r;
    end
    lowest_terms(an_s, an, ad_s, ad);
    lowest_terms(bn_s, bn, bd_s, bd);
    rd_s = 0;
    case (op_t'(it.req_type))
      OP_ADD, OP_SUB: begin
        t1_s = an_s; t1 = an * bd;
        t2_s = (op_t'(it.req_type) == OP_SUB) ? !bn_s : bn_s;
        t2 = bn * ad;
        if (t2 == 0) t2_s = 0;
        if (t1_s == t2_s) begin
          rn_s = t1_s; rn = t1 + t2;
        end else if (t1 >= t2) begin
          rn_s = t1_s; rn = t1 - t2;
        end else begin
          rn_s = t2_s; rn = t2 - t1;
        end
        if (rn == 0) rn_s = 0;
        rd = ad * bd;
      end
      OP_MUL: begin
        rn_s = an_s != bn_s; rn = an * bn; rd = ad * bd;
      end
      default: begin
        if (bn == 0) begin
          r.status = ST_DIV_ZERO;
          return r;
        end
        rn_s = an_s != bn_s; rn = an * bd; rd = ad * bn;
      end
    endcase
    lowest_terms(rn_s, rn, rd_s, rd);
    if (rn == 0) rd = 1;
    if ((rn_s ? (rn > half) : (rn > half - 1)) || rd > half - 1) begin
      r.status = ST_OVERFLOW;
      return r;
    end
    r.res_num = rn_s ? (32'(0 - rn)) : 32'(rn);
    r.res_den = 31'(rd);
    r.status  = ST_OK;
    return r;
  endfunction

  function automatic rfa_in_t mk(op_t op, int an, int ad, int bn, int bd);
    rfa_in_t it;
    it.req_type = op; it.a_num = an; it.a_den = ad; it.b_num = bn; it.b_den = bd;
    return it;
  endfunction

  function automatic rfa_out_t lit_out(int num, int den, status_t st);
    rfa_out_t o;
    o.res_num = num; o.res_den = 31'(den); o.status = st;
    return o;
  endfunction

  task automatic add_row(rfa_in_t it, bit has_lit, rfa_out_t lit);
    row_t rw;
    rw.item = it; rw.has_lit = has_lit; rw.lit = lit;
    rows.push_back(rw);
  endtask

  // Pick an operand value: mostly small, sometimes extreme or fully random.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return 32'h8000_0000 + $urandom_range(0, 3);
      2:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
      3:       return $urandom_range(0, 2) - 1;
      4, 5:    return $urandom_range(0, 65535) - 32768;
      default: return $urandom_range(0, 200) - 100;
    endcase
  endfunction

  // Issue one beat: drop start for a random gap, then hold it until accepted.
  task automatic send_beat(rfa_in_t it, bit has_lit, rfa_out_t lit);
    int gap;
    gap = $urandom_range(0, 18);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    // Beat taken at the edge that ends the wait, the first with busy low; record what it should produce.
    pending_q.push_back(has_lit ? lit : predict_fraction(it));
  endtask

  // Result checker: compare each strobed result with the oldest expectation.
  always @(posedge clk) begin
    rfa_out_t want;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result num=%0d den=%0d status=%0d",
               out_data.res_num, out_data.res_den, out_data.status);
        n_fail++;
      end else begin
        want = pending_q.pop_front();
        if (out_data.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_data.status);
          n_fail++;
        end
        if (out_data.res_num !== want.res_num) begin
          $error("res_num expected %0d actual %0d", want.res_num, out_data.res_num);
          n_fail++;
        end
        if (out_data.res_den !== want.res_den) begin
          $error("res_den expected %0d actual %0d", want.res_den, out_data.res_den);
          n_fail++;
        end
      end
    end
  end

  // Watchdog: end the run on a hung block.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rfa_out_t none;
    rfa_in_t  it;
    int       k;
    none = '0;
    n_fail = 0; cycles = 0;
    rst_n = 1'b0; start = 1'b0; in_data = '0;

    // Extremes and special cases with obvious answers.
    add_row(mk(OP_ADD, 1, 0, 1, 1), 1, lit_out(0, 0, ST_ZERO_DEN));
    add_row(mk(OP_DIV, 1, 1, 0, 0), 1, lit_out(0, 0, ST_ZERO_DEN));
    add_row(mk(OP_DIV, 3, 4, 0, 5), 1, lit_out(0, 0, ST_DIV_ZERO));
    add_row(mk(OP_MUL, 0, 7, 5, 3), 1, lit_out(0, 1, ST_OK));
    add_row(mk(OP_SUB, 2, 3, 4, 6), 1, lit_out(0, 1, ST_OK));
    add_row(mk(OP_ADD, 1, 2, 1, 2), 1, lit_out(1, 1, ST_OK));
    add_row(mk(OP_MUL, 32'h7FFF_FFFF, 1, 2, 1), 1, lit_out(0, 0, ST_OVERFLOW));
    add_row(mk(OP_MUL, 32'h8000_0000, 1, 1, 1), 1, lit_out(32'h8000_0000, 1, ST_OK));
    add_row(mk(OP_MUL, 32'h8000_0000, 1, -1, 1), 1, lit_out(0, 0, ST_OVERFLOW));
    add_row(mk(OP_DIV, 1, 32'h8000_0000, 1, 1), 1, lit_out(0, 0, ST_OVERFLOW));
    add_row(mk(OP_ADD, 1, 32'h7FFF_FFFF, 0, 1), 1, lit_out(1, 32'h7FFF_FFFF, ST_OK));
    // Predictor-checked rows: sign handling, every op, wide cross products.
    add_row(mk(OP_ADD, -3, 4, 5, -6), 0, none);
    add_row(mk(OP_SUB, 7, -9, -2, 3), 0, none);
    add_row(mk(OP_MUL, -6, -35, 14, 15), 0, none);
    add_row(mk(OP_DIV, 5, 8, -15, 16), 0, none);
    add_row(mk(OP_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h7FFF_FFFD), 0, none);
    add_row(mk(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000), 0, none);
    add_row(mk(OP_DIV, 32'h8000_0000, 32'h8000_0000, -1, -1), 0, none);
    add_row(mk(OP_MUL, -1, -1, -1, -1), 0, none);
    add_row(mk(OP_DIV, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 3), 0, none);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_beat(rows[i].item, rows[i].has_lit, rows[i].lit);

    // Random part: mostly valid fractions, some zero denominators.
    for (k = 0; k < N_RANDOM; k++) begin
      it.req_type = 2'($urandom_range(0, 3));
      it.a_num = pick_word();
      it.b_num = pick_word();
      it.a_den = pick_word();
      it.b_den = pick_word();
      if ($urandom_range(0, 19) != 0 && it.a_den == 0) it.a_den = 1;
      if ($urandom_range(0, 19) != 0 && it.b_den == 0) it.b_den = -1;
      send_beat(it, 0, none);
    end
    start <= 1'b0;

    // Drain, then allow a short tail for stray strobes.
    while (pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (n_fail == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/rfa_pkg.sv
rtl/rational_fraction_alu.sv
verif/rational_fraction_alu_tb.sv
